>>> rtl/perlin_gradient_noise_turbulence_defines.svh
// Assertion helpers shared by the FIFO and engine RTL files.
`ifndef PERLIN_GRADIENT_NOISE_TURBULENCE_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_TURBULENCE_DEFINES_SVH
`ifndef SYNTH
`define PGNT_AST_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PGNT_AST_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PGNT_AST_NOW(lbl, clk, rstn, ante, cons)
`define PGNT_AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/pgnt_pkg.sv
`default_nettype none
package pgnt_pkg;

	localparam int PGNT_TABLE_SIZE  = 256;
	localparam int PGNT_MAX_OCTAVES = 8;
	localparam int PGNT_FRAC_BITS   = 16;
	localparam int PGNT_GRAD_FRAC   = 14;
	localparam int PGNT_QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_PERM  = 2'd0,
		KIND_GRAD  = 2'd1,
		KIND_NOISE = 2'd2,
		KIND_TURB  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         index;
		logic [7:0]         perm_x_value;
		logic [7:0]         perm_y_value;
		logic [7:0]         perm_z_value;
		logic signed [15:0] grad_x;
		logic signed [15:0] grad_y;
		logic signed [15:0] grad_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [3:0]         octaves;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FADE_A,
		ST_FADE_B,
		ST_HASH,
		ST_MUL,
		ST_SUM,
		ST_TERM,
		ST_ACC,
		ST_OCT,
		ST_DONE
	} eng_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pgnt_fifo.sv
`default_nettype none
`include "perlin_gradient_noise_turbulence_defines.svh"
module pgnt_fifo import pgnt_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = PGNT_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`PGNT_AST_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`PGNT_AST_NEXT(a_cnt_up, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
	`PGNT_AST_NEXT(a_head_data, clk, arst_n, do_push && empty, rdata == $past(wdata))

endmodule
`default_nettype wire

>>> rtl/pgnt_front.sv
`default_nettype none
module pgnt_front import pgnt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         index,
	input  wire logic [7:0]         perm_x_value,
	input  wire logic [7:0]         perm_y_value,
	input  wire logic [7:0]         perm_z_value,
	input  wire logic signed [15:0] grad_x,
	input  wire logic signed [15:0] grad_y,
	input  wire logic signed [15:0] grad_z,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic [3:0]         octaves,
	input  wire logic               item_pop,
	output item_t                   item,
	output logic                    item_empty
);
	item_t             in_item;
	logic [$bits(item_t)-1:0] head;

	// classify the command
	always_comb begin
		case (cmd)
			KIND_PERM:  in_item.kind = KIND_PERM;
			KIND_GRAD:  in_item.kind = KIND_GRAD;
			KIND_NOISE: in_item.kind = KIND_NOISE;
			default:    in_item.kind = KIND_TURB;
		endcase
		in_item.index        = index;
		in_item.perm_x_value = perm_x_value;
		in_item.perm_y_value = perm_y_value;
		in_item.perm_z_value = perm_z_value;
		in_item.grad_x       = grad_x;
		in_item.grad_y       = grad_y;
		in_item.grad_z       = grad_z;
		in_item.point_x      = point_x;
		in_item.point_y      = point_y;
		in_item.point_z      = point_z;
		in_item.octaves      = octaves;
	end

	pgnt_fifo #(.W($bits(item_t)), .DEPTH(PGNT_QUEUE_DEPTH)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_item),
		.full  (full),
		.pop   (item_pop),
		.rdata (head),
		.empty (item_empty)
	);

	assign item = item_t'(head);

endmodule
`default_nettype wire

>>> rtl/pgnt_engine.sv
`default_nettype none
`include "perlin_gradient_noise_turbulence_defines.svh"
module pgnt_engine import pgnt_pkg::*; #(
	parameter int TABLE_SIZE  = PGNT_TABLE_SIZE,
	parameter int MAX_OCTAVES = PGNT_MAX_OCTAVES,
	parameter int FRAC_BITS   = PGNT_FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire item_t         item,
	input  wire logic          item_empty,
	output logic               item_pop,
	output logic               res_push,
	output logic signed [31:0] res_value,
	input  wire logic          res_full
);
	localparam int IW   = $clog2(TABLE_SIZE);
	localparam int F    = FRAC_BITS;
	localparam int PW   = 32 + MAX_OCTAVES + IW;
	localparam int WW   = F + 1;
	localparam int DW   = F + 2;
	localparam int PRW  = 16 + DW;
	localparam int SUMW = PRW + 2;
	localparam int DOTW = SUMW - PGNT_GRAD_FRAC;
	localparam int NW   = DOTW + 4;
	localparam int TW   = NW + MAX_OCTAVES;
	localparam int OW   = $clog2(MAX_OCTAVES + 1);
	localparam int MW   = 2 * F + 2;
	localparam int TRW  = DOTW + WW + 1;
	localparam logic [WW-1:0]  ONE_W   = {1'b1, {F{1'b0}}};
	localparam logic [F+1:0]   THREE_W = {2'b11, {F{1'b0}}};
	localparam logic signed [DW-1:0] ONE_D = {2'b01, {F{1'b0}}};

	eng_state_t state_q, state_d;

	logic [7:0]  perm_x_mem [TABLE_SIZE];
	logic [7:0]  perm_y_mem [TABLE_SIZE];
	logic [7:0]  perm_z_mem [TABLE_SIZE];
	logic [47:0] grad_mem   [TABLE_SIZE];

	logic [7:0]  px_q [2];
	logic [7:0]  py_q [2];
	logic [7:0]  pz_q [2];
	logic [47:0] grad_rd_q;

	logic signed [PW-1:0]  pt_q [3];
	logic [2*F-1:0]        ff_q [3];
	logic [WW-1:0]         fade_q [3];
	logic signed [PRW-1:0] gp_q [3];
	logic [MW-1:0]         wxy_q, wfull_q;
	logic signed [DOTW-1:0] dot_q;
	logic signed [TRW-1:0] term_q;
	logic signed [NW-1:0]  acc_q;
	logic signed [TW-1:0]  tacc_q;
	logic [2:0]            c_q;
	logic [OW-1:0]         o_q, oct_q;
	logic                  turb_q;

	logic [IW-1:0] widx, hash;
	logic [IW-1:0] lat_idx [3];
	logic [F-1:0]  fr [3];
	logic [WW-1:0] wt [3];
	logic signed [DW-1:0] dd [3];
	logic signed [15:0]   gv [3];
	logic signed [SUMW-1:0] dsum;
	logic [OW-1:0] oct_n, shamt;
	logic          load_perm, load_grad;
	logic signed [63:0] tacc64, mag64;

	assign widx      = IW'(item.index);
	assign load_perm = item_pop && (item.kind == KIND_PERM);
	assign load_grad = item_pop && (item.kind == KIND_GRAD);
	assign oct_n     = (item.octaves > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(item.octaves);
	assign shamt     = OW'(MAX_OCTAVES - 1) - o_q;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lat_idx[a] = pt_q[a][F+IW-1:F];
			fr[a]      = pt_q[a][F-1:0];
			wt[a]      = c_q[2-a] ? fade_q[a] : ONE_W - fade_q[a];
			dd[a]      = $signed({2'b00, fr[a]}) - (c_q[2-a] ? ONE_D : '0);
		end
		gv[0] = grad_rd_q[47:32];
		gv[1] = grad_rd_q[31:16];
		gv[2] = grad_rd_q[15:0];
		hash  = IW'(px_q[c_q[2]]) ^ IW'(py_q[c_q[1]]) ^ IW'(pz_q[c_q[0]]);
		dsum  = SUMW'(gp_q[0]) + SUMW'(gp_q[1]) + SUMW'(gp_q[2]);
	end

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (load_perm) begin
			perm_x_mem[widx] <= item.perm_x_value;
			perm_y_mem[widx] <= item.perm_y_value;
			perm_z_mem[widx] <= item.perm_z_value;
		end
		if (load_grad) begin
			grad_mem[widx] <= {item.grad_x, item.grad_y, item.grad_z};
		end
		px_q[0]   <= perm_x_mem[lat_idx[0]];
		px_q[1]   <= perm_x_mem[lat_idx[0] + 1'b1];
		py_q[0]   <= perm_y_mem[lat_idx[1]];
		py_q[1]   <= perm_y_mem[lat_idx[1] + 1'b1];
		pz_q[0]   <= perm_z_mem[lat_idx[2]];
		pz_q[1]   <= perm_z_mem[lat_idx[2] + 1'b1];
		grad_rd_q <= grad_mem[hash];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pt_q[0] <= PW'(item.point_x);
				pt_q[1] <= PW'(item.point_y);
				pt_q[2] <= PW'(item.point_z);
				acc_q   <= '0;
				tacc_q  <= '0;
			end
			ST_FADE_A: begin
				for (int a = 0; a < 3; a++) begin
					ff_q[a] <= fr[a] * fr[a];
				end
			end
			ST_FADE_B: begin
				for (int a = 0; a < 3; a++) begin
					fade_q[a] <= WW'((MW'(ff_q[a][2*F-1:F]) * MW'(THREE_W - {fr[a], 1'b0})) >> F);
				end
			end
			ST_MUL: begin
				for (int a = 0; a < 3; a++) begin
					gp_q[a] <= gv[a] * dd[a];
				end
				wxy_q <= MW'(wt[0]) * MW'(wt[1]);
			end
			ST_SUM: begin
				dot_q   <= dsum[SUMW-1:PGNT_GRAD_FRAC];
				wfull_q <= MW'(wxy_q[2*F:F]) * MW'(wt[2]);
			end
			ST_TERM: begin
				term_q <= TRW'(dot_q) * $signed(TRW'({1'b0, wfull_q[2*F:F]}));
			end
			ST_ACC: begin
				acc_q <= acc_q + NW'($signed(term_q[TRW-1:F]));
			end
			ST_OCT: begin
				// fold the octave into turbulence; a plain noise sum stays for the result
				if (turb_q) begin
					tacc_q <= tacc_q + (TW'(acc_q) <<< shamt);
					acc_q  <= '0;
				end
				for (int a = 0; a < 3; a++) begin
					pt_q[a] <= pt_q[a] <<< 1;
				end
			end
			default: begin
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			o_q     <= '0;
			oct_q   <= '0;
			turb_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_pop) begin
				turb_q <= (item.kind == KIND_TURB);
				oct_q  <= (item.kind == KIND_TURB) ? oct_n : OW'(1);
				o_q    <= '0;
				c_q    <= '0;
			end
			if (state_q == ST_ACC) begin
				c_q <= c_q + 1'b1;
			end
			if (state_q == ST_OCT) begin
				o_q <= o_q + 1'b1;
			end
		end
	end

	always_comb begin
		tacc64 = 64'(tacc_q);
		mag64  = (tacc64 < 0) ? -tacc64 : tacc64;
		if (turb_q) begin
			res_value = sat32(mag64 >>> (MAX_OCTAVES - 1));
		end else begin
			res_value = sat32(64'(acc_q));
		end
	end

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_pop = !item_empty;
				if (!item_empty) begin
					if (item.kind == KIND_NOISE) begin
						state_d = ST_FADE_A;
					end else if (item.kind == KIND_TURB) begin
						state_d = (oct_n == '0) ? ST_DONE : ST_FADE_A;
					end
				end
			end
			ST_FADE_A: state_d = ST_FADE_B;
			ST_FADE_B: state_d = ST_HASH;
			ST_HASH:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_TERM;
			ST_TERM:   state_d = ST_ACC;
			ST_ACC:    state_d = (c_q == 3'd7) ? ST_OCT : ST_HASH;
			ST_OCT:    state_d = ((o_q + OW'(1)) == oct_q) ? ST_DONE : ST_FADE_A;
			ST_DONE: begin
				res_push = !res_full;
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	`PGNT_AST_NOW(a_pop_idle, clk, arst_n, item_pop, state_q == ST_IDLE)
	`PGNT_AST_NEXT(a_last_corner, clk, arst_n, state_q == ST_ACC && c_q == 3'd7, state_q == ST_OCT)
	`PGNT_AST_NOW(a_oct_range, clk, arst_n, state_q != ST_IDLE, oct_q <= OW'(MAX_OCTAVES))

endmodule
`default_nettype wire

>>> rtl/perlin_gradient_noise_turbulence.sv
`default_nettype none
// 3D gradient noise with optional turbulence, signed Q16.16 in and out.
// Input channel: push/full queue. cmd 0 loads the three permutation entries
// at index, cmd 1 loads the gradient at index; neither gives a result.
// cmd 2 evaluates noise at the point, cmd 3 sums 0..8 octaves of it and
// takes the absolute value; each gives one result.
// Result channel: empty/pop queue; noise_value holds the oldest result while
// empty is low, and a pop transfers it.
// A two-entry command queue separates acceptance from the engine, and a
// two-entry result queue separates the engine from the consumer, so input
// keeps being taken while a finished result waits.
// In the engine, a load is written to its table as it is dequeued. Each
// octave runs the fade states FADE_A and FADE_B, then for each lattice corner
// the HASH, MUL, SUM, TERM and ACC states through the single shared corner
// datapath and the one gradient table read port, then the OCT state, which
// doubles the point and, for turbulence, folds the octave into the sum.
// Reset clears the queues and the engine state; table contents survive reset
// and must be loaded before use. A stalled consumer fills the result queue,
// then the engine holds in its done state, then the command queue fills and
// full rises.
module perlin_gradient_noise_turbulence import pgnt_pkg::*; #(
	parameter int TABLE_SIZE  = PGNT_TABLE_SIZE,
	parameter int MAX_OCTAVES = PGNT_MAX_OCTAVES,
	parameter int FRAC_BITS   = PGNT_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         index,
	input  wire logic [7:0]         perm_x_value,
	input  wire logic [7:0]         perm_y_value,
	input  wire logic [7:0]         perm_z_value,
	input  wire logic signed [15:0] grad_x,
	input  wire logic signed [15:0] grad_y,
	input  wire logic signed [15:0] grad_z,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	input  wire logic [3:0]         octaves,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      noise_value
);
	item_t              item;
	logic               item_empty, item_pop;
	logic               res_push, res_full;
	logic signed [31:0] res_value;

	// front: accept and classify each transfer
	pgnt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.index       (index),
		.perm_x_value(perm_x_value),
		.perm_y_value(perm_y_value),
		.perm_z_value(perm_z_value),
		.grad_x      (grad_x),
		.grad_y      (grad_y),
		.grad_z      (grad_z),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.octaves     (octaves),
		.item_pop    (item_pop),
		.item        (item),
		.item_empty  (item_empty)
	);

	// back: tables and the noise engine
	pgnt_engine #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_OCTAVES(MAX_OCTAVES),
		.FRAC_BITS  (FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.res_push  (res_push),
		.res_value (res_value),
		.res_full  (res_full)
	);

	// hold finished results until the consumer pops them
	pgnt_fifo #(.W(32), .DEPTH(PGNT_QUEUE_DEPTH)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_value),
		.full  (res_full),
		.pop   (pop),
		.rdata (noise_value),
		.empty (empty)
	);

endmodule
`default_nettype wire

>>> test/perlin_gradient_noise_turbulence_checker.sv
module perlin_gradient_noise_turbulence_checker import pgnt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         cmd,
	input  logic [7:0]         index,
	input  logic [7:0]         perm_x_value,
	input  logic [7:0]         perm_y_value,
	input  logic [7:0]         perm_z_value,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic [3:0]         octaves,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [31:0] noise_value,
	output int                 errors,
	output int                 pending
);
	localparam longint ONE = 64'sd1 <<< PGNT_FRAC_BITS;

	logic [7:0] hash_x [PGNT_TABLE_SIZE];
	logic [7:0] hash_y [PGNT_TABLE_SIZE];
	logic [7:0] hash_z [PGNT_TABLE_SIZE];
	longint grad_tab [PGNT_TABLE_SIZE][3];
	logic signed [31:0] noise_due [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic longint smooth(longint f);
		longint f2;
		f2 = (f * f) >>> PGNT_FRAC_BITS;
		return (f2 * (3 * ONE - 2 * f)) >>> PGNT_FRAC_BITS;
	endfunction

	function automatic longint lattice_noise(longint px, longint py, longint pz);
		longint cx, cy, cz, fx, fy, fz, sx, sy, sz, acc, dx, dy, dz, dot, wx, wy, wz, w;
		logic [7:0] ix, iy, iz, h;
		acc = 0;
		cx = px >>> PGNT_FRAC_BITS;
		cy = py >>> PGNT_FRAC_BITS;
		cz = pz >>> PGNT_FRAC_BITS;
		fx = px & (ONE - 1);
		fy = py & (ONE - 1);
		fz = pz & (ONE - 1);
		sx = smooth(fx);
		sy = smooth(fy);
		sz = smooth(fz);
		for (int di = 0; di < 2; di++) begin
			for (int dj = 0; dj < 2; dj++) begin
				for (int dk = 0; dk < 2; dk++) begin
					ix = cx[7:0] + di[7:0];
					iy = cy[7:0] + dj[7:0];
					iz = cz[7:0] + dk[7:0];
					h = hash_x[ix] ^ hash_y[iy] ^ hash_z[iz];
					dx = fx - di * ONE;
					dy = fy - dj * ONE;
					dz = fz - dk * ONE;
					dot = (grad_tab[h][0] * dx + grad_tab[h][1] * dy
						+ grad_tab[h][2] * dz) >>> PGNT_GRAD_FRAC;
					wx = di ? sx : ONE - sx;
					wy = dj ? sy : ONE - sy;
					wz = dk ? sz : ONE - sz;
					w = (((wx * wy) >>> PGNT_FRAC_BITS) * wz) >>> PGNT_FRAC_BITS;
					acc += (dot * w) >>> PGNT_FRAC_BITS;
				end
			end
		end
		return acc;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] turbulence(longint px, longint py, longint pz,
			int oct);
		longint acc;
		acc = 0;
		if (oct > PGNT_MAX_OCTAVES)
			oct = PGNT_MAX_OCTAVES;
		for (int o = 0; o < oct; o++)
			acc += lattice_noise(px <<< o, py <<< o, pz <<< o)
				<<< (PGNT_MAX_OCTAVES - 1 - o);
		if (acc < 0)
			acc = -acc;
		return clamp32(acc >>> (PGNT_MAX_OCTAVES - 1));
	endfunction

	task automatic report_mismatch(string what, logic signed [31:0] got,
			logic signed [31:0] want);
		$display("noise_value %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			case (kind_t'(cmd))
				KIND_PERM: begin
					hash_x[index] = perm_x_value;
					hash_y[index] = perm_y_value;
					hash_z[index] = perm_z_value;
				end
				KIND_GRAD: begin
					grad_tab[index][0] = grad_x;
					grad_tab[index][1] = grad_y;
					grad_tab[index][2] = grad_z;
				end
				KIND_NOISE: noise_due.push_back(clamp32(lattice_noise(point_x, point_y,
					point_z)));
				KIND_TURB: noise_due.push_back(turbulence(point_x, point_y, point_z,
					octaves));
			endcase
		end
		if (arst_n && pop && !empty) begin
			if (noise_due.size() == 0)
				report_mismatch("unexpected", noise_value, 'x);
			else if (noise_value !== noise_due[0])
				report_mismatch("wrong", noise_value, noise_due.pop_front());
			else
				void'(noise_due.pop_front());
		end
		pending = noise_due.size();
	end
endmodule

>>> test/tb.sv
module tb import pgnt_pkg::*;;
	localparam int LIMIT = 10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [31:0] noise_value;
	item_t cur = '0;
	int errors, pending;
	int cycles = 0;
	int stall_left = 0;
	// steady phase: consumer pops every cycle, sender never idles
	bit steady = 1'b0;

	always #1 clk = ~clk;

	perlin_gradient_noise_turbulence DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd(cur.kind), .index(cur.index),
		.perm_x_value(cur.perm_x_value), .perm_y_value(cur.perm_y_value),
		.perm_z_value(cur.perm_z_value),
		.grad_x(cur.grad_x), .grad_y(cur.grad_y), .grad_z(cur.grad_z),
		.point_x(cur.point_x), .point_y(cur.point_y), .point_z(cur.point_z),
		.octaves(cur.octaves), .empty(empty), .pop(pop), .noise_value(noise_value)
	);

	perlin_gradient_noise_turbulence_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd(cur.kind), .index(cur.index),
		.perm_x_value(cur.perm_x_value), .perm_y_value(cur.perm_y_value),
		.perm_z_value(cur.perm_z_value),
		.grad_x(cur.grad_x), .grad_y(cur.grad_y), .grad_z(cur.grad_z),
		.point_x(cur.point_x), .point_y(cur.point_y), .point_z(cur.point_z),
		.octaves(cur.octaves), .empty(empty), .pop(pop), .noise_value(noise_value),
		.errors(errors), .pending(pending)
	);

	// Bail out on a hang: a stuck handshake or a result that never arrives.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("perlin_gradient_noise_turbulence: mismatch");
			$finish;
		end
	end

	// Consumer: mostly short random stalls, now and then a long one.
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (steady) begin
			pop <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else begin
			if (r < 3)
				stall_left <= $urandom_range(30, 300);
			pop <= (r >= 30);
		end
	end

	// Hold the item until its transfer, then, outside the steady phase, sometimes idle for a random gap.
	task automatic transfer(item_t it);
		int g;
		g = $urandom_range(0, 99);
		push <= 1'b1;
		cur <= it;
		do @(posedge clk); while (full);
		if (!steady && g >= 60) begin
			push <= 1'b0;
			repeat (g >= 97 ? $urandom_range(20, 150) : $urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	function automatic item_t rand_item();
		item_t it;
		int r;
		it.index = 8'($urandom);
		it.perm_x_value = 8'($urandom);
		it.perm_y_value = 8'($urandom);
		it.perm_z_value = 8'($urandom);
		r = $urandom_range(0, 9);
		// mostly unit range, sometimes any 16-bit pattern
		it.grad_x = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		it.grad_y = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		it.grad_z = (r == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
		r = $urandom_range(0, 9);
		it.point_x = (r < 4) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
		it.point_y = (r < 4) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
		it.point_z = (r < 4) ? $urandom : $signed($urandom_range(0, 2000000)) - 1000000;
		if (r == 9)
			it.point_x = ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
		it.octaves = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, 4));
		r = $urandom_range(0, 99);
		it.kind = (r < 10) ? KIND_PERM : (r < 20) ? KIND_GRAD : (r < 65) ? KIND_NOISE
			: KIND_TURB;
		return it;
	endfunction

	initial begin
		item_t it;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every table entry before anything reads it.
		for (int i = 0; i < PGNT_TABLE_SIZE; i++) begin
			it = rand_item();
			it.kind = KIND_PERM;
			it.index = 8'(i);
			transfer(it);
			it = rand_item();
			it.kind = KIND_GRAD;
			it.index = 8'(i);
			// gradients outside unit range, used as given
			if (i == 5) begin
				it.grad_x = 16'sh7FFF;
				it.grad_y = 16'sh8000;
				it.grad_z = 16'sh7FFF;
			end
			transfer(it);
		end

		// Directed: extreme points and octave counts.
		for (int k = 0; k < 16; k++) begin
			it = rand_item();
			it.kind = (k < 5) ? KIND_NOISE : KIND_TURB;
			case (k % 5)
				0: begin it.point_x = 0; it.point_y = 0; it.point_z = 0; end
				1: begin
					it.point_x = 32'sh7FFFFFFF;
					it.point_y = 32'sh7FFFFFFF;
					it.point_z = 32'sh7FFFFFFF;
				end
				2: begin
					it.point_x = 32'sh80000000;
					it.point_y = 32'sh80000000;
					it.point_z = 32'sh80000000;
				end
				3: begin it.point_x = 32'hFFFF; it.point_y = -1; it.point_z = 32'h1FFFF; end
				default: ;
			endcase
			it.octaves = (k < 5) ? 4'd0 : 4'(k - 5);
			transfer(it);
		end

		// Drain once completely with the sender held off.
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		for (int n = 0; n < 1600; n++) begin
			steady <= (n >= 700 && n < 800);
			transfer(rand_item());
		end
		push <= 1'b0;
		steady <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("perlin_gradient_noise_turbulence: match");
		else
			$display("perlin_gradient_noise_turbulence: mismatch");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl
rtl/pgnt_pkg.sv
rtl/pgnt_fifo.sv
rtl/pgnt_front.sv
rtl/pgnt_engine.sv
rtl/perlin_gradient_noise_turbulence.sv
test/perlin_gradient_noise_turbulence_checker.sv
test/tb.sv
